// ===== hdl/array_list_store_macros.svh =====
// Assertion macros shared by the list store modules.
`ifndef ARRAY_LIST_STORE_MACROS_SVH
`define ARRAY_LIST_STORE_MACROS_SVH
`ifndef SYNTH
// Clocked check that is switched off while reset is asserted.
`define ALS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("array_list_store: assertion failed");
// Clocked check that also holds during reset.
`define ALS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("array_list_store: assertion failed");
`else
`define ALS_ASSERT(name, clk, rst_n, prop)
`define ALS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== hdl/alc_pkg.sv =====
// Types, widths and helper functions for the list store.
package alc_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int CMD_W        = 3;
    localparam int INDEX_W      = 10;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int LENGTH_W     = 11;
    // Positions reach CAPACITY-1, and CAPACITY is at most 65536.
    localparam int POS_W        = 16;
    // Width in which indexes and counts are compared.
    localparam int CMP_W        = 17;
    localparam int TREE_RADIX   = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    // Broadcast from the command decoder to every cell.
    typedef struct packed {
        logic              load;
        logic              rd;
        cell_op_t          op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } cell_ctl_t;

    // Number of radix-4 levels needed to cover n leaves, at least one.
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv   = 1;
        span = TREE_RADIX;
        while (span < n) begin
            span = span * TREE_RADIX;
            lv   = lv + 1;
        end
        return lv;
    endfunction

endpackage

// ===== hdl/alc_req_if.sv =====
// Command channel of the list store.
interface alc_req_if import alc_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [INDEX_W-1:0]       index;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, output command, output index, output data_in,
                    input ready);
    modport sink   (input valid, input command, input index, input data_in,
                    output ready);

endinterface

// ===== hdl/alc_rsp_if.sv =====
// Result channel of the list store.
interface alc_rsp_if import alc_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;
    logic [LENGTH_W-1:0]      length;

    modport source (output valid, output data_out, output status, output length,
                    input ready);
    modport sink   (input valid, input data_out, input status, input length,
                    output ready);

endinterface

// ===== hdl/alc_cell.sv =====
// One list position: holds an entry and trades it with its neighbours.
module alc_cell import alc_pkg::*; #(
    parameter int POS = 0
) (
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [DATA_W-1:0] prev_entry,
    input  logic [DATA_W-1:0] next_entry,
    output logic [DATA_W-1:0] entry,
    output logic [DATA_W-1:0] tap
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [DATA_W-1:0] tap_reg;
    logic [DATA_W-1:0] tap_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_WRITE:
            begin
                if (ctl.pos == MY_POS)
                begin
                    entry_next = ctl.data;
                end
            end
            CELL_INSERT:
            begin
                if (ctl.pos == MY_POS)
                begin
                    entry_next = ctl.data;
                end
                else if (MY_POS > ctl.pos)
                begin
                    entry_next = prev_entry;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_POS >= ctl.pos)
                begin
                    entry_next = next_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // On a taken command the tap captures the old entry on a read hit and zero otherwise.
    always_comb
    begin
        tap_next = tap_reg;
        if (ctl.load)
        begin
            tap_next = (ctl.rd && (ctl.pos == MY_POS)) ? entry_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule

// ===== hdl/alc_tree.sv =====
// Registered radix-4 OR tree that gathers the one live cell tap.
module alc_tree import alc_pkg::*; #(
    parameter int LEAVES = CAPACITY_DEF,
    parameter int LEVELS = tree_levels(LEAVES)
) (
    input  logic              clk,
    input  logic [DATA_W-1:0] leaf [LEAVES],
    output logic [DATA_W-1:0] root
);

    // Heap layout: node k has children TREE_RADIX*k+1 .. TREE_RADIX*k+TREE_RADIX;
    // indexes past the last inner node are leaves.
    localparam int INNER = ((TREE_RADIX ** LEVELS) - 1) / (TREE_RADIX - 1);

    logic [DATA_W-1:0] node_reg [INNER];
    logic [DATA_W-1:0] kid_w    [INNER][TREE_RADIX];

    for (genvar k = 0; k < INNER; k++)
    begin : g_node
        for (genvar j = 0; j < TREE_RADIX; j++)
        begin : g_kid
            localparam int CH = TREE_RADIX * k + 1 + j;
            if (CH >= INNER)
            begin : g_leaf
                if (CH - INNER < LEAVES)
                begin : g_live
                    assign kid_w[k][j] = leaf[CH - INNER];
                end
                else
                begin : g_pad
                    assign kid_w[k][j] = '0;
                end
            end
            else
            begin : g_inner
                assign kid_w[k][j] = node_reg[CH];
            end
        end

        always_ff @(posedge clk)
        begin
            node_reg[k] <= kid_w[k][0] | kid_w[k][1] | kid_w[k][2] | kid_w[k][3];
        end
    end

    assign root = node_reg[0];

endmodule

// ===== hdl/array_list_store.sv =====
// Top level of the list store: a row of CAPACITY cells with a registered read-out tree.
// A result beat follows its command beat through the cell taps, the LEVELS registered
// tree levels (LEVELS = ceil(log4 CAPACITY), at least one) and the output register.
// No command is taken while the tree is busy; shifts and writes land as it is taken.
// Reset clears the count and the handshake state; entries are not cleared and need no sweep.
`include "array_list_store_macros.svh"
module array_list_store import alc_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    alc_req_if.sink      req,
    alc_rsp_if.source    rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = tree_levels(CAPACITY);
    localparam int BUSY_W = $clog2(LEVELS + 1);

    // ------------------------------------------------------------------
    // Control and result registers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [BUSY_W-1:0]   busy_cnt_reg;
    logic [BUSY_W-1:0]   busy_cnt_next;
    logic                res_pend_reg;
    logic                res_pend_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [LENGTH_W-1:0] res_length_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [DATA_W-1:0]   rsp_data_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [LENGTH_W-1:0] rsp_length_reg;

    logic                acc;
    logic                out_free;
    logic                move_res;

    // ------------------------------------------------------------------
    // Command decode. The index check runs against the count before the
    // command; it also rejects insert at the tail position.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    cnt_new_ext;
    logic [POS_W-1:0]    idx_pos;
    logic [POS_W-1:0]    tail_pos;
    logic                in_range;
    logic                full;
    status_t             st_sel;
    cell_op_t            op_sel;
    logic                rd_sel;
    logic [POS_W-1:0]    pos_sel;
    logic [CNT_W-1:0]    count_new;
    cell_ctl_t           cell_ctl;

    assign idx_ext  = CMP_W'(req.index);
    assign cnt_ext  = CMP_W'(count_reg);
    assign idx_pos  = POS_W'(req.index);
    assign tail_pos = cnt_ext[POS_W-1:0];
    assign in_range = idx_ext < cnt_ext;
    assign full     = count_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        st_sel    = ST_OK;
        op_sel    = CELL_HOLD;
        rd_sel    = 1'b0;
        pos_sel   = idx_pos;
        count_new = count_reg;
        unique case (cmd_t'(req.command))
            CMD_GET:
            begin
                if (in_range)
                begin
                    rd_sel = 1'b1;
                end
                else
                begin
                    st_sel = ST_RANGE;
                end
            end
            CMD_SET:
            begin
                if (in_range)
                begin
                    op_sel = CELL_WRITE;
                end
                else
                begin
                    st_sel = ST_RANGE;
                end
            end
            CMD_APPEND:
            begin
                if (full)
                begin
                    st_sel = ST_FULL;
                end
                else
                begin
                    op_sel    = CELL_WRITE;
                    pos_sel   = tail_pos;
                    count_new = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (!in_range)
                begin
                    st_sel = ST_RANGE;
                end
                else if (full)
                begin
                    st_sel = ST_FULL;
                end
                else
                begin
                    op_sel    = CELL_INSERT;
                    count_new = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (in_range)
                begin
                    op_sel    = CELL_REMOVE;
                    rd_sel    = 1'b1;
                    count_new = count_reg - CNT_W'(1);
                end
                else
                begin
                    st_sel = ST_RANGE;
                end
            end
            default:
            begin
                // Codes with no meaning are rejected like a bad index.
                st_sel = ST_RANGE;
            end
        endcase
    end

    assign cnt_new_ext = CMP_W'(count_new);

    // The cells see a command only in the cycle its beat is taken.
    always_comb
    begin
        cell_ctl.load = acc;
        cell_ctl.rd   = acc & rd_sel;
        cell_ctl.op   = acc ? op_sel : CELL_HOLD;
        cell_ctl.pos  = pos_sel;
        cell_ctl.data = $unsigned(req.data_in);
    end

    // ------------------------------------------------------------------
    // Row of cells. Insert pulls from the lower neighbour, remove from the
    // upper one; the ends of the row are fed with zero.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] entry_w [CAPACITY];
    logic [DATA_W-1:0] tap_w   [CAPACITY];
    logic [DATA_W-1:0] prev_w  [CAPACITY];
    logic [DATA_W-1:0] next_w  [CAPACITY];
    logic [DATA_W-1:0] root_w;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign prev_w[i] = '0;
        end
        else
        begin : g_prev
            assign prev_w[i] = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_w[i] = '0;
        end
        else
        begin : g_next
            assign next_w[i] = entry_w[i+1];
        end

        alc_cell #(
            .POS (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .prev_entry (prev_w[i]),
            .next_entry (next_w[i]),
            .entry      (entry_w[i]),
            .tap        (tap_w[i])
        );
    end

    // The taps hold still between commands, so the root settles once the change has
    // passed every tree level and then stays put until the next command.
    alc_tree #(
        .LEAVES (CAPACITY),
        .LEVELS (LEVELS)
    ) u_tree (
        .clk  (clk),
        .leaf (tap_w),
        .root (root_w)
    );

    // ------------------------------------------------------------------
    // Handshake. A command is taken once the tree is free and any finished
    // result can move to the output register in the same cycle, so a
    // waiting result beat does not hold up the next command.
    // ------------------------------------------------------------------
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign move_res  = res_pend_reg && out_free;
    assign req.ready = (busy_cnt_reg == '0) && (!res_pend_reg || out_free);
    assign acc       = req.valid && req.ready;

    always_comb
    begin
        count_next    = acc ? count_new : count_reg;
        busy_cnt_next = busy_cnt_reg;
        res_pend_next = res_pend_reg;
        if (acc)
        begin
            busy_cnt_next = BUSY_W'(LEVELS);
        end
        else if (busy_cnt_reg != '0)
        begin
            busy_cnt_next = busy_cnt_reg - BUSY_W'(1);
        end

        if (!acc && (busy_cnt_reg == BUSY_W'(1)))
        begin
            res_pend_next = 1'b1;
        end
        else if (move_res)
        begin
            res_pend_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (move_res)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_cnt_reg  <= '0;
            res_pend_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_cnt_reg  <= busy_cnt_next;
            res_pend_reg  <= res_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Status and length are known at once; the data follows from the tree.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            res_status_reg <= st_sel;
            res_length_reg <= cnt_new_ext[LENGTH_W-1:0];
        end
        if (move_res)
        begin
            rsp_data_reg   <= root_w;
            rsp_status_reg <= res_status_reg;
            rsp_length_reg <= res_length_reg;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.data_out = $signed(rsp_data_reg);
    assign rsp.status   = rsp_status_reg;
    assign rsp.length   = rsp_length_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `ALS_ASSERT(a_count_step, clk, rst_n,
        acc |=> (count_reg == $past(count_reg)) ||
                (count_reg == $past(count_reg) + CNT_W'(1)) ||
                (count_reg == $past(count_reg) - CNT_W'(1)))
    `ALS_ASSERT(a_reject_keeps_count, clk, rst_n,
        acc && (st_sel != ST_OK) |=> count_reg == $past(count_reg))
    `ALS_ASSERT(a_idle_keeps_count, clk, rst_n, !acc |=> count_reg == $past(count_reg))
    `ALS_ASSERT(a_pend_after_tree, clk, rst_n, res_pend_reg |-> busy_cnt_reg == '0)
    `ALS_ASSERT_ALWAYS(a_count_bound, clk, count_reg <= CNT_W'(CAPACITY))

endmodule
